@@ hw/rtl/pli_pkg.sv @@
// ----------------------------------------------------------------------------
// pli_pkg: shared types and constants for the positional list core
// Sizes of the slot row, field widths, operation codes and the control
// bundle that is broadcast from the sequencer to every slot cell.
// ----------------------------------------------------------------------------
package pli_pkg;

	// Number of slots in the row of cells.
	localparam int CAPACITY = 64;

	// Fixed field widths of the request and response beats.
	localparam int DATA_W = 32;
	localparam int POS_W  = 7;
	localparam int LEN_W  = 7;
	localparam int OP_W   = 2;

	// Slot index and internal element count widths follow the capacity.
	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	// Width wide enough to compare a position against the count plus one.
	localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

	// Read reduction: slots are ORed in groups, with one registered level after the groups.
	localparam int GRP_SIZE = 8;
	localparam int GRP_CNT  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_GET    = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	// Status codes.
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	// Control bundle seen by every slot cell.
	typedef struct packed {
		logic              go;      // apply the shift or write this cycle
		logic              ins;     // insert: open a gap at idx
		logic              del;     // delete: close the gap at idx
		logic [IDX_W-1:0]  idx;     // zero-based target slot
		logic [DATA_W-1:0] value;   // word placed by an insert
	} cell_ctl_t;

endpackage

@@ hw/rtl/pli_req_if.sv @@
// ----------------------------------------------------------------------------
// pli_req_if: request channel of the positional list core
// Valid/ready channel carrying one get, insert or delete request per beat.
// ----------------------------------------------------------------------------
interface pli_req_if import pli_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          opcode;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] new_value;

	modport source (output valid, output opcode, output position, output new_value,
		input ready);
	modport sink (input valid, input opcode, input position, input new_value,
		output ready);

endinterface

@@ hw/rtl/pli_rsp_if.sv @@
// ----------------------------------------------------------------------------
// pli_rsp_if: response channel of the positional list core
// Valid/ready channel carrying one status, data word and length per beat.
// ----------------------------------------------------------------------------
interface pli_rsp_if import pli_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic                     status;
	logic signed [DATA_W-1:0] read_value;
	logic [LEN_W-1:0]         list_length;

	modport source (output valid, output status, output read_value,
		output list_length, input ready);
	modport sink (input valid, input status, input read_value, input list_length,
		output ready);

endinterface

@@ hw/rtl/positional_list_insert_delete_core.sv @@
// ----------------------------------------------------------------------------
// positional_list_insert_delete_core: ordered list with positional access
// Keeps an ordered list of signed 32-bit words in a row of slot cells and
// serves get, insert and delete requests at a 1-based position.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Beat content
//   -------  ---------  ---------------------------------------------
//   req      in         opcode, position, new_value
//   rsp      out        status, read_value, list_length
//
// A response is loaded after the sequencer has passed EXEC, where every cell
// shifts or loads while the addressed word enters the read reduction, and
// REDUCE, where the final level feeds the output register. A request is
// accepted only in IDLE. Reset clears only the count, the sequencer and the
// output valid flag. A response left in the output register still lets the
// next request in; its result then waits in REDUCE until the register is free.
//
module positional_list_insert_delete_core import pli_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	pli_req_if.sink       req,
	pli_rsp_if.source     rsp
);

	// Sequencer states, one-hot.
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_EXEC   = 3'b010,
		ST_REDUCE = 3'b100
	} state_t;

	state_t state_q;

	// Request captured at the accepting edge.
	logic [OP_W-1:0]   op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [DATA_W-1:0] val_q;
	logic              ok_q;

	// Element count.
	logic [CNT_W-1:0]  count_q;

	// Output register.
	logic              rsp_valid_q;
	logic              rsp_status_q;
	logic [DATA_W-1:0] rsp_data_q;
	logic [LEN_W-1:0]  rsp_len_q;

	// Request checks, done against the count at the accepting edge.
	logic [CMP_W-1:0]  pos_x;
	logic [CMP_W-1:0]  cnt_x;
	logic [POS_W-1:0]  pos_m1;
	logic              pos_nz;
	logic              req_ok;
	logic              accept;
	logic              rsp_load;

	// Slot row wiring.
	cell_ctl_t         ctl;
	logic [DATA_W-1:0] cell_data [CAPACITY];
	logic [DATA_W-1:0] cell_tap [CAPACITY];
	logic [DATA_W-1:0] read_word;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	assign pos_x  = CMP_W'(req.position);
	assign cnt_x  = CMP_W'(count_q);
	assign pos_m1 = req.position - POS_W'(1);
	assign pos_nz = (req.position != '0);

	// A get or delete needs a position within the list; an insert may also
	// name the slot just past the end, provided the list is not full.
	always_comb begin
		unique case (req.opcode) inside
			OP_GET, OP_DELETE: req_ok = pos_nz && (pos_x <= cnt_x);
			OP_INSERT:         req_ok = pos_nz && (pos_x <= cnt_x + CMP_W'(1)) &&
				(cnt_x < CMP_W'(CAPACITY));
			default:           req_ok = 1'b0;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_REDUCE;
				end
				ST_REDUCE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture; payload needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.opcode;
			idx_q <= IDX_W'(pos_m1);
			val_q <= req.new_value;
			ok_q  <= req_ok;
		end
	end

	// The count moves in the same cycle as the slot row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (state_q == ST_EXEC && ok_q) begin
			if (op_q == OP_INSERT) begin
				count_q <= count_q + CNT_W'(1);
			end else if (op_q == OP_DELETE) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Broadcast control to the cells.
	always_comb begin
		ctl.go    = (state_q == ST_EXEC) && ok_q;
		ctl.ins   = (op_q == OP_INSERT);
		ctl.del   = (op_q == OP_DELETE);
		ctl.idx   = idx_q;
		ctl.value = val_q;
	end

	// The row of slot cells: each is wired to its two neighbours. The ends
	// see zero, which is never taken into a slot that is later read.
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;

		if (k == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_inner_l
			assign left_w = cell_data[k-1];
		end

		if (k == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_inner_r
			assign right_w = cell_data[k+1];
		end

		pli_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.slot       (IDX_W'(k)),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cell_data[k]),
			.tap        (cell_tap[k])
		);
	end

	// The addressed word is sampled while the cells still hold the old
	// contents, i.e. at the same edge at which they shift.
	pli_read_tree u_read_tree (
		.clk  (clk),
		.en   (state_q == ST_EXEC),
		.tap  (cell_tap),
		.word (read_word)
	);

	// Output register: loads when the result is ready and the slot is free.
	assign rsp_load = (state_q == ST_REDUCE) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q <= ok_q ? STATUS_OK : STATUS_ERR;
			rsp_data_q   <= (ok_q && (op_q != OP_INSERT)) ? read_word : '0;
			rsp_len_q    <= LEN_W'(count_q);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.read_value  = rsp_data_q;
	assign rsp.list_length = rsp_len_q;

endmodule

@@ hw/rtl/pli_cell.sv @@
// ----------------------------------------------------------------------------
// pli_cell: one slot of the list
// Holds one word, offered when addressed; on an insert a cell above the target
// takes the left neighbour's word, on a delete one at or above it the right's.
// ----------------------------------------------------------------------------
module pli_cell import pli_pkg::*; (
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [IDX_W-1:0]  slot,
	input  logic [DATA_W-1:0] left_data,
	input  logic [DATA_W-1:0] right_data,
	output logic [DATA_W-1:0] data,
	output logic [DATA_W-1:0] tap
);

	logic [DATA_W-1:0] word_q;
	logic              hit;
	logic              above;

	assign hit   = (slot == ctl.idx);
	assign above = (slot > ctl.idx);

	always_ff @(posedge clk) begin
		if (ctl.go) begin
			if (ctl.ins) begin
				if (hit) begin
					word_q <= ctl.value;
				end else if (above) begin
					word_q <= left_data;
				end
			end else if (ctl.del) begin
				if (hit || above) begin
					word_q <= right_data;
				end
			end
		end
	end

	assign data = word_q;
	assign tap  = hit ? word_q : '0;

endmodule

@@ hw/rtl/pli_read_tree.sv @@
// ----------------------------------------------------------------------------
// pli_read_tree: registered OR reduction of the slot taps
// At most one tap is non-zero; groups are ORed and registered, then the
// group results are ORed into the read word.
// ----------------------------------------------------------------------------
module pli_read_tree import pli_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [DATA_W-1:0] tap [CAPACITY],
	output logic [DATA_W-1:0] word
);

	logic [DATA_W-1:0] grp_or [GRP_CNT];
	logic [DATA_W-1:0] grp_or_s1 [GRP_CNT];

	always_comb begin
		for (int g = 0; g < GRP_CNT; g++) begin
			grp_or[g] = '0;
			for (int j = 0; j < GRP_SIZE; j++) begin
				if (g * GRP_SIZE + j < CAPACITY) begin
					grp_or[g] = grp_or[g] | tap[g * GRP_SIZE + j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < GRP_CNT; g++) begin
				grp_or_s1[g] <= grp_or[g];
			end
		end
	end

	always_comb begin
		word = '0;
		for (int g = 0; g < GRP_CNT; g++) begin
			word = word | grp_or_s1[g];
		end
	end

endmodule
